/* src/tcw_pkg.sv */
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants and types for the text console writer: screen geometry,
// control characters, stream word layouts and controller states.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int COLS  = 80;
    localparam int ROWS  = 25;
    localparam int CELLS = ROWS * COLS;

    localparam int X_W    = 7;
    localparam int Y_W    = 5;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int CELL_W = 16;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 32;

    localparam int TAB_STOP  = 8;
    localparam int TAB_LSB_W = $clog2(TAB_STOP);
    localparam int RESET_ROW = (17 < ROWS) ? 17 : ROWS - 1;

    localparam logic [7:0] CH_TAB = 8'd9;
    localparam logic [7:0] CH_LF  = 8'd10;
    localparam logic [7:0] CH_CR  = 8'd13;

    localparam logic [7:0]        BLANK_ATTR  = 8'h07;
    localparam logic [7:0]        RESET_ATTR  = 8'd14;
    localparam logic [CELL_W-1:0] BLANK_CELL  = {BLANK_ATTR, 8'h00};

    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_READ  = 3'b100
    } t_state;

endpackage

/* src/text_console_writer_core.sv */
// ----------------------------------------------------------------------------
// text_console_writer_core
// 80x25 text console: screen memory of char/attribute cells plus a cursor.
//
// Input stream (s side): one word per put or read. tuser is the opcode
// (0 put character, 1 read one cell). Output stream (m side): one word per
// input word, carrying the read cell (zero on put) and the cursor after it.
// Config channel: writes the attribute byte stored with printed characters.
//
// Rows live in the memory as a ring: a scroll advances the top-row pointer
// and blanks the row that becomes the bottom, one cell per cycle.
// A put writes its cell and registers its output word; a read registers the
// memory cell, then forms the output word in S_READ. A put that scrolls then
// blanks one row of COLS (80) cells before the next word is taken.
// After reset the block runs a clearing pass over all CELLS (2000) entries,
// one per cycle, and takes no input word meanwhile; config writes are taken.
// The output word sits in a register; a new input word is taken while it
// is being taken or after it is gone, so a stalled receiver stalls the input.
// ----------------------------------------------------------------------------
module text_console_writer_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // config write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [7:0]                      i_cfg_data,
    // input stream
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // [7:0] char_code, [12:8] read_row, [19:13] read_col
    input  logic [tcw_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    // [0] opcode
    input  logic                            i_s_tuser,
    // output stream
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // [7:0] cell_char, [15:8] cell_attr, [22:16] cursor_col, [27:23] cursor_row
    output logic [tcw_pkg::OUT_TDATA_W-1:0] o_m_tdata
);
    import tcw_pkg::*;

    logic [CELL_W-1:0] r_mem [0:CELLS-1];
    logic [CELL_W-1:0] r_rd_data;

    t_state            r_state, n_state;
    logic [X_W-1:0]    r_x, n_x;
    logic [Y_W-1:0]    r_y, n_y;
    logic [Y_W-1:0]    r_top, n_top;
    logic [7:0]        r_attr, n_attr;
    logic [ADDR_W-1:0] r_clr_addr, n_clr_addr;
    logic [ADDR_W-1:0] r_clr_last, n_clr_last;
    logic              r_rd_oob, n_rd_oob;
    logic              r_out_valid, n_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data, n_out_data;

    logic              s_acc;
    logic              out_free;
    logic [7:0]        in_char;
    logic [Y_W-1:0]    in_row;
    logic [X_W-1:0]    in_col;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;

    logic              put_wr;
    logic              new_line;
    logic              scroll;
    logic [X_W-1:0]    put_x;
    logic [Y_W-1:0]    put_y;
    logic [X_W-1:0]    tab_x;
    logic [Y_W:0]      rd_sum;
    logic [Y_W-1:0]    rd_phys;
    logic [Y_W:0]      wr_sum;
    logic [Y_W-1:0]    wr_phys;
    logic              oob;
    logic [ADDR_W-1:0] top_base;

    assign in_char = i_s_tdata[7:0];
    assign in_row  = i_s_tdata[12:8];
    assign in_col  = i_s_tdata[19:13];

    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_valid || i_m_tready;
    assign o_s_tready  = (r_state == S_IDLE) && out_free;
    assign s_acc       = i_s_tvalid && o_s_tready;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_data;

    // logical row -> physical row in the ring
    always_comb begin
        rd_sum = {1'b0, r_top} + {1'b0, in_row};
        if (rd_sum >= (Y_W+1)'(ROWS)) begin
            rd_sum = rd_sum - (Y_W+1)'(ROWS);
        end
        rd_phys = rd_sum[Y_W-1:0];
        wr_sum  = {1'b0, r_top} + {1'b0, r_y};
        if (wr_sum >= (Y_W+1)'(ROWS)) begin
            wr_sum = wr_sum - (Y_W+1)'(ROWS);
        end
        wr_phys = wr_sum[Y_W-1:0];
    end

    assign oob      = (in_row >= Y_W'(ROWS)) || (in_col >= X_W'(COLS));
    assign top_base = ADDR_W'(r_top) * ADDR_W'(COLS);
    assign rd_addr  = oob ? '0 : ADDR_W'(rd_phys) * ADDR_W'(COLS) + ADDR_W'(in_col);
    assign rd_en    = s_acc && (i_s_tuser == OP_READ);

    // cursor update for a put
    always_comb begin
        put_wr   = 1'b0;
        new_line = 1'b0;
        scroll   = 1'b0;
        put_x    = r_x;
        put_y    = r_y;
        tab_x    = {r_x[X_W-1:TAB_LSB_W], TAB_LSB_W'(0)} + X_W'(TAB_STOP);
        case (in_char)
            CH_LF: begin
                new_line = 1'b1;
            end
            CH_TAB: begin
                if (tab_x >= X_W'(COLS)) begin
                    new_line = 1'b1;
                end else begin
                    put_x = tab_x;
                end
            end
            CH_CR: begin
                put_x = '0;
            end
            default: begin
                put_wr = 1'b1;
                if (r_x == X_W'(COLS - 1)) begin
                    new_line = 1'b1;
                end else begin
                    put_x = r_x + X_W'(1);
                end
            end
        endcase
        if (new_line) begin
            put_x = '0;
            if (r_y == Y_W'(ROWS - 1)) begin
                scroll = 1'b1;
            end else begin
                put_y = r_y + Y_W'(1);
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_x         = r_x;
        n_y         = r_y;
        n_top       = r_top;
        n_attr      = r_attr;
        n_clr_addr  = r_clr_addr;
        n_clr_last  = r_clr_last;
        n_rd_oob    = r_rd_oob;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_data  = r_out_data;
        mem_we      = 1'b0;
        mem_waddr   = r_clr_addr;
        mem_wdata   = BLANK_CELL;

        if (i_cfg_valid) begin
            n_attr = i_cfg_data;
        end

        case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                if (r_clr_addr == r_clr_last) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + ADDR_W'(1);
                end
            end
            S_IDLE: begin
                if (s_acc) begin
                    if (i_s_tuser == OP_READ) begin
                        n_rd_oob = oob;
                        n_state  = S_READ;
                    end else begin
                        mem_we      = put_wr;
                        mem_waddr   = ADDR_W'(wr_phys) * ADDR_W'(COLS) + ADDR_W'(r_x);
                        mem_wdata   = {r_attr, in_char};
                        n_x         = put_x;
                        n_y         = put_y;
                        n_out_valid = 1'b1;
                        n_out_data  = OUT_TDATA_W'({put_y, put_x, 16'h0000});
                        if (scroll) begin
                            // old top row becomes the new bottom row; blank it
                            n_top      = (r_top == Y_W'(ROWS - 1)) ? '0 : r_top + Y_W'(1);
                            n_clr_addr = top_base;
                            n_clr_last = top_base + ADDR_W'(COLS - 1);
                            n_state    = S_CLEAR;
                        end
                    end
                end
            end
            S_READ: begin
                n_out_valid = 1'b1;
                n_out_data  = OUT_TDATA_W'({r_y, r_x, r_rd_oob ? 16'h0000 : r_rd_data});
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_x         <= '0;
            r_y         <= Y_W'(RESET_ROW);
            r_top       <= '0;
            r_attr      <= RESET_ATTR;
            r_clr_addr  <= '0;
            r_clr_last  <= ADDR_W'(CELLS - 1);
            r_rd_oob    <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_data  <= '0;
        end else begin
            r_state     <= n_state;
            r_x         <= n_x;
            r_y         <= n_y;
            r_top       <= n_top;
            r_attr      <= n_attr;
            r_clr_addr  <= n_clr_addr;
            r_clr_last  <= n_clr_last;
            r_rd_oob    <= n_rd_oob;
            r_out_valid <= n_out_valid;
            r_out_data  <= n_out_data;
        end
    end

endmodule

/* test/tb_text_console_writer_core.sv */
// ----------------------------------------------------------------------------
// tb_text_console_writer_core
// Self-checking bench for the text console writer. A shadow screen, cursor
// and attribute track every accepted word, and each output word is compared
// with the oldest predicted cell/cursor view. Stimulus is a short directed
// run (reads in and out of the screen, extreme bytes, CR, tab wrap, scroll),
// then random put/read traffic under several attribute settings with random
// stalls on both streams, one long receiver hold and a calm final stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_text_console_writer_core;

    import tcw_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int LONG_HOLD   = 400;
    localparam int PHASE_WORDS = 320;

    typedef struct packed {
        logic       op;
        logic [7:0] ch;
        logic [4:0] row;
        logic [6:0] col;
    } t_console_cmd;

    typedef struct packed {
        logic [7:0] chr;
        logic [7:0] attr;
        logic [6:0] cx;
        logic [4:0] cy;
    } t_console_view;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [7:0]             i_cfg_data  = '0;
    logic                   i_s_tvalid  = 1'b0;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata   = '0;
    logic                   i_s_tuser   = 1'b0;
    logic                   o_m_tvalid;
    logic                   i_m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_tdata;

    text_console_writer_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    // shadow of the console
    logic [CELL_W-1:0] shadow_screen [0:CELLS-1];
    int unsigned       cur_x;
    int unsigned       cur_y;
    logic [7:0]        shadow_attr;

    t_console_cmd  cmd_q[$];
    t_console_view view_q[$];

    int unsigned tx_gap       = 0;
    int unsigned rx_gap       = 0;
    int unsigned rx_hold_left = 0;
    bit          rx_hold_req  = 1'b0;
    bit          calm         = 1'b0;
    int          error_count  = 0;
    int unsigned cycle_count  = 0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("text_console_writer_core verification failed");
            $finish;
        end
    end

    // ---------------- predictor ----------------
    function automatic void scroll_shadow();
        for (int i = 0; i < CELLS; i++)
            shadow_screen[i] = (i + COLS < CELLS) ? shadow_screen[i + COLS] : BLANK_CELL;
    endfunction

    function automatic void cursor_newline();
        cur_x = 0;
        cur_y++;
        if (cur_y > ROWS - 1) begin
            scroll_shadow();
            cur_y = ROWS - 1;
        end
    endfunction

    function automatic t_console_view console_step(input t_console_cmd c);
        t_console_view v;
        v = '0;
        if (c.op == OP_PUT) begin
            if (c.ch == CH_LF) begin
                cursor_newline();
            end else if (c.ch == CH_TAB) begin
                cur_x = cur_x + TAB_STOP - (cur_x % TAB_STOP);
                if (cur_x >= COLS)
                    cursor_newline();
            end else if (c.ch == CH_CR) begin
                cur_x = 0;
            end else begin
                shadow_screen[cur_y * COLS + cur_x] = {shadow_attr, c.ch};
                cur_x++;
                if (cur_x > COLS - 1)
                    cursor_newline();
            end
        end else if (c.row < ROWS && c.col < COLS) begin
            {v.attr, v.chr} = shadow_screen[c.row * COLS + c.col];
        end
        v.cx = 7'(cur_x);
        v.cy = 5'(cur_y);
        return v;
    endfunction

    // ---------------- input side ----------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (tx_gap > 0) begin
            i_s_tvalid <= 1'b0;
            tx_gap--;
        end else if (cmd_q.size() != 0) begin
            i_s_tvalid <= 1'b1;
            i_s_tdata  <= {4'b0, cmd_q[0].col, cmd_q[0].row, cmd_q[0].ch};
            i_s_tuser  <= cmd_q[0].op;
        end else begin
            i_s_tvalid <= 1'b0;
        end
    end

    // accepted word: predict from what was on the bus
    always @(posedge i_clk) begin
        t_console_cmd c;
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            c.op  = i_s_tuser;
            c.ch  = i_s_tdata[7:0];
            c.row = i_s_tdata[12:8];
            c.col = i_s_tdata[19:13];
            view_q.push_back(console_step(c));
            void'(cmd_q.pop_front());
            if (!calm && $urandom_range(0, 5) == 0)
                tx_gap = $urandom_range(1, 8);
        end
    end

    // ---------------- output side ----------------
    always @(negedge i_clk) begin
        if (rx_hold_req) begin
            rx_hold_left = LONG_HOLD;
            rx_hold_req  = 1'b0;
        end
        if (rx_hold_left > 0) begin
            i_m_tready <= 1'b0;
            rx_hold_left--;
        end else if (rx_gap > 0) begin
            i_m_tready <= 1'b0;
            rx_gap--;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            i_m_tready <= 1'b0;
            rx_gap = $urandom_range(1, 8) - 1;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_console_view want;
        t_console_view got;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.chr  = o_m_tdata[7:0];
            got.attr = o_m_tdata[15:8];
            got.cx   = o_m_tdata[22:16];
            got.cy   = o_m_tdata[27:23];
            if (view_q.size() == 0) begin
                $error("unexpected output word %h", o_m_tdata);
                error_count++;
            end else begin
                want = view_q.pop_front();
                if (got.chr !== want.chr) begin
                    $error("cell_char mismatch: expected %0d, got %0d", want.chr, got.chr);
                    error_count++;
                end
                if (got.attr !== want.attr) begin
                    $error("cell_attr mismatch: expected %0d, got %0d", want.attr, got.attr);
                    error_count++;
                end
                if (got.cx !== want.cx) begin
                    $error("cursor_col mismatch: expected %0d, got %0d", want.cx, got.cx);
                    error_count++;
                end
                if (got.cy !== want.cy) begin
                    $error("cursor_row mismatch: expected %0d, got %0d", want.cy, got.cy);
                    error_count++;
                end
            end
        end
    end

    // ---------------- sequencing ----------------
    function automatic void queue_cmd(input logic op, input logic [7:0] ch,
                                      input logic [4:0] row, input logic [6:0] col);
        t_console_cmd c;
        c.op  = op;
        c.ch  = ch;
        c.row = row;
        c.col = col;
        cmd_q.push_back(c);
    endfunction

    function automatic void queue_random(input int count);
        t_console_cmd c;
        int unsigned  pick;
        for (int n = 0; n < count; n++) begin
            c.op = ($urandom_range(0, 3) == 0) ? OP_READ : OP_PUT;
            pick = $urandom_range(0, 99);
            if (pick < 8)
                c.ch = CH_LF;
            else if (pick < 14)
                c.ch = CH_TAB;
            else if (pick < 18)
                c.ch = CH_CR;
            else
                c.ch = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 9) == 0) begin
                c.row = 5'($urandom_range(0, 31));
                c.col = 7'($urandom_range(0, 127));
            end else begin
                c.row = 5'($urandom_range(0, ROWS - 1));
                c.col = 7'($urandom_range(0, COLS - 1));
            end
            cmd_q.push_back(c);
        end
    endfunction

    // wait for every word to come back, then let a trailing scroll finish
    task automatic drain();
        while (cmd_q.size() != 0 || view_q.size() != 0)
            @(posedge i_clk);
        repeat (COLS + 8) @(posedge i_clk);
    endtask

    task automatic write_attr(input logic [7:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        shadow_attr = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        for (int i = 0; i < CELLS; i++)
            shadow_screen[i] = BLANK_CELL;
        cur_x       = 0;
        cur_y       = RESET_ROW;
        shadow_attr = RESET_ATTR;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reads at the top-left corner and off screen, extreme bytes,
        // CR, tab chain that wraps the line, LFs down into a scroll
        queue_cmd(OP_READ, 8'hFF, 5'd0, 7'd0);
        queue_cmd(OP_READ, CH_LF, 5'd31, 7'd127);
        queue_cmd(OP_READ, 8'h00, 5'(ROWS - 1), 7'(COLS));
        queue_cmd(OP_PUT, 8'h41, 5'd31, 7'd127);
        queue_cmd(OP_PUT, 8'h00, 5'd0, 7'd0);
        queue_cmd(OP_PUT, 8'hFF, 5'd0, 7'd0);
        queue_cmd(OP_READ, 8'h00, 5'(RESET_ROW), 7'd0);
        queue_cmd(OP_READ, 8'h00, 5'(RESET_ROW), 7'd2);
        queue_cmd(OP_PUT, CH_CR, 5'd0, 7'd0);
        repeat (COLS / TAB_STOP) queue_cmd(OP_PUT, CH_TAB, 5'd0, 7'd0);
        repeat (ROWS - RESET_ROW) queue_cmd(OP_PUT, CH_LF, 5'd0, 7'd0);
        queue_cmd(OP_READ, 8'h00, 5'(RESET_ROW - 1), 7'd0);
        drain();

        // receiver holds off while the sender keeps offering
        write_attr(8'hFF);
        rx_hold_req = 1'b1;
        queue_random(PHASE_WORDS);
        drain();

        write_attr(8'h00);
        queue_random(PHASE_WORDS);
        drain();

        write_attr(8'($urandom_range(1, 254)));
        queue_random(PHASE_WORDS);
        drain();

        write_attr(8'($urandom_range(0, 255)));
        queue_random(PHASE_WORDS);
        drain();

        // back-to-back traffic, no stalls
        write_attr(BLANK_ATTR);
        calm = 1'b1;
        queue_random(PHASE_WORDS);
        drain();

        if (error_count == 0) begin
            $display("text_console_writer_core verification clean");
        end else begin
            $display("text_console_writer_core verification failed");
        end
        $finish;
    end

endmodule

/* sim.f */
src/tcw_pkg.sv
src/text_console_writer_core.sv
test/tb_text_console_writer_core.sv
